// ----- rtl/owl_pkg.sv -----
// ----------------------------------------------------------------------------
// owl_pkg
// Shared types, constants and helper functions of the one-wire bus master.
// ----------------------------------------------------------------------------
package owl_pkg;

	// Width of every timing register and of the configuration data path.
	localparam int CFG_W = 10;
	// Number of timing registers.
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	// Width of the tick countdown.
	localparam int TIME_WIDTH = 10;
	localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_WIDTH) - 64'd1);
	// Low time of a read slot, in ticks.
	localparam logic [CFG_W-1:0] READ_LOW_TICKS = CFG_W'(3);

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RESET_WAIT    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_ONE_LOW       = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH      = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW      = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH     = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_READ_RECOVERY = REG_IDX_W'(7);

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_regs_t;

	// Values of the timing registers after reset.
	localparam cfg_regs_t CFG_DEFAULTS = {
		CFG_W'(45), CFG_W'(15), CFG_W'(10), CFG_W'(100),
		CFG_W'(70), CFG_W'(8), CFG_W'(70), CFG_W'(480)
	};

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_RESET = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LOW     = 3'd1,
		PH_HIGH    = 3'd2,
		PH_SAMPLE  = 3'd3,
		PH_RECOVER = 3'd4
	} phase_t;

	// One result item.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       rejected;
	} owl_res_t;

	// Converts a register value to a countdown load: zero counts as one tick
	// and values beyond the countdown range saturate.
	function automatic logic [TIME_WIDTH-1:0] load_time(input logic [CFG_W-1:0] t);
		logic [31:0] v;
		v = 32'(t);
		if (v == 32'd0) v = 32'd1;
		if (v > TIME_MAX) v = TIME_MAX;
		return v[TIME_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/owl_cmd_if.sv -----
// ----------------------------------------------------------------------------
// owl_cmd_if
// Input channel of the one-wire bus master: tick or command items.
// ----------------------------------------------------------------------------
interface owl_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] write_data;
	logic       line_level;

	modport source (output valid, output mode, output write_data, output line_level,
		input ready);
	modport sink (input valid, input mode, input write_data, input line_level,
		output ready);
endinterface

// ----- rtl/owl_res_if.sv -----
// ----------------------------------------------------------------------------
// owl_res_if
// Output channel of the one-wire bus master: one status item per input item.
// ----------------------------------------------------------------------------
interface owl_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output read_data, output rejected, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input read_data, input rejected, output ready);
endinterface

// ----- rtl/owl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// owl_cfg_regs
// Bank of timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module owl_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [owl_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [owl_pkg::CFG_W-1:0]     cfg_wr_data,
	output owl_pkg::cfg_regs_t            regs
);
	import owl_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_DEFAULTS;
		end else if (cfg_wr_en) begin
			regs_q[cfg_index] <= cfg_wr_data;
		end
	end

	assign regs = regs_q;
endmodule

// ----- rtl/owl_seq.sv -----
// ----------------------------------------------------------------------------
// owl_seq
// Bus sequencer: holds the command state and works out, for each accepted
// item, the next state and the status that results from it.
// ----------------------------------------------------------------------------
module owl_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         mode,
	input  logic [7:0]         write_data,
	input  logic               line_level,
	input  owl_pkg::cfg_regs_t regs,
	output owl_pkg::owl_res_t  res
);
	import owl_pkg::*;

	phase_t                phase_q, phase_n;
	logic [1:0]            kind_q, kind_n;
	logic [2:0]            bit_q, bit_n;
	logic [TIME_WIDTH-1:0] cnt_q, cnt_n;
	logic [7:0]            shift_q, shift_n;
	logic [7:0]            rd_q, rd_n;
	logic                  drive_q, drive_n;

	logic                  finish;
	logic                  rejected;
	logic [TIME_WIDTH-1:0] cnt_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= 2'd0;
			bit_q   <= 3'd0;
			cnt_q   <= '0;
			shift_q <= 8'd0;
			rd_q    <= 8'd0;
			drive_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			bit_q   <= bit_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			rd_q    <= rd_n;
			drive_q <= drive_n;
		end
	end

	assign cnt_dec = (cnt_q != '0) ? cnt_q - TIME_WIDTH'(1) : '0;

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		bit_n    = bit_q;
		cnt_n    = cnt_q;
		shift_n  = shift_q;
		rd_n     = rd_q;
		drive_n  = drive_q;
		finish   = 1'b0;
		rejected = 1'b0;

		if (mode == MODE_TICK) begin
			if (phase_q != PH_IDLE) begin
				cnt_n = cnt_dec;
				if (cnt_dec == '0) begin
					case (phase_q)
						PH_LOW: begin
							drive_n = 1'b0;
							if (kind_q == MODE_RESET) begin
								phase_n = PH_HIGH;
								cnt_n   = load_time(regs[REG_RESET_WAIT]);
							end else if (kind_q == MODE_WRITE) begin
								phase_n = PH_HIGH;
								cnt_n   = load_time(shift_q[0] ? regs[REG_ONE_HIGH]
									: regs[REG_ZERO_HIGH]);
							end else begin
								phase_n = PH_SAMPLE;
								cnt_n   = load_time(regs[REG_READ_SAMPLE]);
							end
						end
						PH_HIGH: begin
							if (kind_q == MODE_RESET) begin
								finish = 1'b1;
							end else begin
								// End of a write slot: drop the bit just sent.
								shift_n = {1'b0, shift_q[7:1]};
								if (bit_q == 3'd7) begin
									bit_n  = 3'd0;
									finish = 1'b1;
								end else begin
									bit_n   = bit_q + 3'd1;
									drive_n = 1'b1;
									phase_n = PH_LOW;
									cnt_n   = load_time(shift_q[1] ? regs[REG_ONE_LOW]
										: regs[REG_ZERO_LOW]);
								end
							end
						end
						PH_SAMPLE: begin
							shift_n = {line_level, shift_q[7:1]};
							phase_n = PH_RECOVER;
							cnt_n   = load_time(regs[REG_READ_RECOVERY]);
						end
						PH_RECOVER: begin
							if (bit_q == 3'd7) begin
								bit_n  = 3'd0;
								rd_n   = shift_q;
								finish = 1'b1;
							end else begin
								bit_n   = bit_q + 3'd1;
								drive_n = 1'b1;
								phase_n = PH_LOW;
								cnt_n   = load_time(READ_LOW_TICKS);
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE) begin
			rejected = 1'b1;
		end else begin
			kind_n  = mode;
			bit_n   = 3'd0;
			drive_n = 1'b1;
			phase_n = PH_LOW;
			if (mode == MODE_RESET) begin
				cnt_n = load_time(regs[REG_RESET_LOW]);
			end else if (mode == MODE_WRITE) begin
				shift_n = write_data;
				cnt_n   = load_time(write_data[0] ? regs[REG_ONE_LOW] : regs[REG_ZERO_LOW]);
			end else begin
				shift_n = 8'd0;
				cnt_n   = load_time(READ_LOW_TICKS);
			end
		end

		if (finish) begin
			phase_n = PH_IDLE;
			drive_n = 1'b0;
			cnt_n   = '0;
		end
	end

	assign res.drive_low = drive_n;
	assign res.busy_res  = (phase_n != PH_IDLE);
	assign res.done_res  = finish;
	assign res.read_data = rd_n;
	assign res.rejected  = rejected;
endmodule

// ----- rtl/one_wire_bus_master_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// Byte-level open-drain one-wire bus master timed by tick items.
// ----------------------------------------------------------------------------
// The cmd channel carries one item per microsecond tick (mode tick) or a
// command: bus reset, byte write or byte read. The line level sampled from
// the bus travels with each item. For every accepted item the res channel
// returns exactly one status transfer: the level to drive on the bus, busy,
// done on the item that finishes a command, the byte of the last finished
// read, and a flag for a command that arrived while busy and was dropped.
// The status of an item is registered in the output register at the clock
// edge of its transfer. One item is accepted every cycle while the output
// register is empty or being read; the whole state update is a single pass
// of logic between the sequencer state and the output register.
// When the receiver stalls, the output register holds its status and the
// cmd channel stays ready only if that status is taken in the same cycle,
// so no status is lost or repeated.
// The user must write the timing registers via the cfg port only while the
// block is idle; the block does not enforce it. Reset idles the sequencer,
// frees the bus, empties the output register, resets timing regs to default.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [owl_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [owl_pkg::CFG_W-1:0]     cfg_wr_data,
	owl_cmd_if.sink                       cmd,
	owl_res_if.source                     res
);
	import owl_pkg::*;

	cfg_regs_t regs;
	owl_res_t  res_next;
	owl_res_t  res_q;
	logic      res_valid_q;
	logic      accept;

	// A new item may enter whenever the output register is empty or its
	// current status is being taken in this same cycle.
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	owl_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.regs        (regs)
	);

	// The sequencer advances its state only on an accepted transfer and
	// presents the resulting status combinationally.
	owl_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (cmd.mode),
		.write_data (cmd.write_data),
		.line_level (cmd.line_level),
		.regs       (regs),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// The status payload needs no reset; it is qualified by the valid flag.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = res_q.drive_low;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.read_data = res_q.read_data;
	assign res.rejected  = res_q.rejected;
endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-wire bus master core: a cycle-accurate
// predictor of the slot sequencer runs alongside the block and every status
// transfer is compared field by field against the predicted status.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import owl_pkg::*;

	// Cycles without any transfer on either channel before the run is declared hung.
	// The longest legal quiet stretch is the deliberate receiver hold-off below.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Length of the long receiver hold-off, in clock cycles.
	localparam int unsigned HOLD_OFF_CYCLES = 500;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wr_data;

	owl_cmd_if cmd_ch ();
	owl_res_if res_ch ();

	one_wire_bus_master_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.res         (res_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state. This mirrors the sequencer of the block: the current
	// phase of a slot, the command in progress, which of the eight bit slots
	// is running, the tick countdown of the current interval, the byte being
	// shifted out or in, the last finished read byte and the bus drive.
	// ------------------------------------------------------------------------
	phase_t                  seq_phase;
	mode_t                   seq_kind;
	logic [2:0]              slot_bit;
	logic [TIME_WIDTH-1:0]   ticks_left;
	logic [7:0]              shift_byte;
	logic [7:0]              last_byte;
	logic                    line_low;
	logic [CFG_W-1:0]        timing_reg [NUM_REGS];

	// Statuses predicted for accepted items, oldest first.
	owl_res_t status_q [$];

	// Idle percentages of the sender and of the receiver, and a hold-off
	// request that the receiver process counts down cycle by cycle.
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned rx_hold_cycles;

	int unsigned fault_count;
	int unsigned quiet_cycles;
	owl_res_t    seen_status;
	owl_res_t    due_status;

	// A register value as a countdown load. A zero register still lasts one
	// tick, and anything the countdown cannot hold is clamped to its maximum.
	function automatic logic [TIME_WIDTH-1:0] ticks_of(input logic [CFG_W-1:0] t);
		logic [31:0] wide;
		wide = 32'(t);
		if (wide == 32'd0)
			wide = 32'd1;
		else if (wide > TIME_MAX)
			wide = TIME_MAX;
		return wide[TIME_WIDTH-1:0];
	endfunction

	function automatic string status_str(input owl_res_t s);
		return $sformatf("drive_low=%0b busy=%0b done=%0b read_data=%02h rejected=%0b",
			s.drive_low, s.busy_res, s.done_res, s.read_data, s.rejected);
	endfunction

	// Reset state of the sequencer and the power-on timing values.
	task automatic reset_model();
		seq_phase  = PH_IDLE;
		seq_kind   = MODE_TICK;
		slot_bit   = '0;
		ticks_left = '0;
		shift_byte = '0;
		last_byte  = '0;
		line_low   = 1'b0;
		timing_reg[REG_RESET_LOW]     = CFG_W'(480);
		timing_reg[REG_RESET_WAIT]    = CFG_W'(70);
		timing_reg[REG_ONE_LOW]       = CFG_W'(8);
		timing_reg[REG_ONE_HIGH]      = CFG_W'(70);
		timing_reg[REG_ZERO_LOW]      = CFG_W'(100);
		timing_reg[REG_ZERO_HIGH]     = CFG_W'(10);
		timing_reg[REG_READ_SAMPLE]   = CFG_W'(15);
		timing_reg[REG_READ_RECOVERY] = CFG_W'(45);
	endtask

	// Opens the low part of the slot for the current bit. Read slots always
	// pull low for the fixed short time; write slots take the one-bit or the
	// zero-bit low time depending on the bit about to go out.
	task automatic open_slot();
		line_low  = 1'b1;
		seq_phase = PH_LOW;
		if (seq_kind == MODE_READ)
			ticks_left = ticks_of(READ_LOW_TICKS);
		else if (shift_byte[0])
			ticks_left = ticks_of(timing_reg[REG_ONE_LOW]);
		else
			ticks_left = ticks_of(timing_reg[REG_ZERO_LOW]);
	endtask

	// Advances the predictor by one accepted item and returns its status.
	task automatic step_bus(input mode_t m, input logic [7:0] wd, input logic lvl,
			output owl_res_t st);
		logic finished;
		logic slot_over;
		finished  = 1'b0;
		slot_over = 1'b0;
		st.rejected = 1'b0;
		if (m == MODE_TICK) begin
			// A tick only counts while a command is running.
			if (seq_phase != PH_IDLE) begin
				if (ticks_left != '0)
					ticks_left = ticks_left - TIME_WIDTH'(1);
				if (ticks_left == '0) begin
					case (seq_phase)
						PH_LOW: begin
							line_low = 1'b0;
							if (seq_kind == MODE_RESET) begin
								seq_phase  = PH_HIGH;
								ticks_left = ticks_of(timing_reg[REG_RESET_WAIT]);
							end else if (seq_kind == MODE_WRITE) begin
								seq_phase  = PH_HIGH;
								ticks_left = ticks_of(shift_byte[0] ?
									timing_reg[REG_ONE_HIGH] : timing_reg[REG_ZERO_HIGH]);
							end else begin
								seq_phase  = PH_SAMPLE;
								ticks_left = ticks_of(timing_reg[REG_READ_SAMPLE]);
							end
						end
						PH_HIGH: begin
							if (seq_kind == MODE_RESET) begin
								finished = 1'b1;
							end else begin
								shift_byte = shift_byte >> 1;
								slot_over  = 1'b1;
							end
						end
						PH_SAMPLE: begin
							// The sampled level enters at the top, so after eight
							// slots the first bit read sits in bit 0.
							shift_byte = {lvl, shift_byte[7:1]};
							seq_phase  = PH_RECOVER;
							ticks_left = ticks_of(timing_reg[REG_READ_RECOVERY]);
						end
						PH_RECOVER: slot_over = 1'b1;
						default: finished = 1'b1;
					endcase
					if (slot_over) begin
						if (slot_bit == 3'd7) begin
							slot_bit = '0;
							finished = 1'b1;
							if (seq_kind == MODE_READ)
								last_byte = shift_byte;
						end else begin
							slot_bit = slot_bit + 3'd1;
							open_slot();
						end
					end
					if (finished) begin
						seq_phase  = PH_IDLE;
						line_low   = 1'b0;
						ticks_left = '0;
					end
				end
			end
		end else if (seq_phase != PH_IDLE) begin
			// A command while busy is dropped and counts no tick.
			st.rejected = 1'b1;
		end else begin
			// Starting a command takes no time: its first interval begins
			// with the next tick.
			seq_kind = m;
			slot_bit = '0;
			if (m == MODE_RESET) begin
				line_low   = 1'b1;
				seq_phase  = PH_LOW;
				ticks_left = ticks_of(timing_reg[REG_RESET_LOW]);
			end else begin
				shift_byte = (m == MODE_WRITE) ? wd : 8'h00;
				open_slot();
			end
		end
		st.drive_low = line_low;
		st.busy_res  = (seq_phase != PH_IDLE);
		st.done_res  = finished;
		st.read_data = last_byte;
	endtask

	// ------------------------------------------------------------------------
	// Sender. Inputs change on the falling edge; a transfer is seen on the
	// rising edge where valid and ready are both high. Valid stays high after
	// a transfer until the next call decides whether to idle or to offer the
	// next item, so it is never lowered and raised within one time step.
	// ------------------------------------------------------------------------
	task automatic send_item(input mode_t m, input logic [7:0] wd, input logic lvl);
		owl_res_t st;
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      = 1'b1;
		cmd_ch.mode       = m;
		cmd_ch.write_data = wd;
		cmd_ch.line_level = lvl;
		do @(posedge clk); while (!cmd_ch.ready);
		step_bus(m, wd, lvl, st);
		status_q.push_back(st);
	endtask

	// A tick with random payload: the data byte is ignored on a tick, and the
	// line level matters only on the tick that ends a read sample wait.
	task automatic send_tick();
		send_item(MODE_TICK, 8'($urandom), 1'($urandom));
	endtask

	// Keeps ticking until the predictor says the running command is over.
	task automatic finish_command();
		while (seq_phase != PH_IDLE)
			send_tick();
	endtask

	// Brings the block to rest: command finished, input channel quiet and
	// every predicted status received.
	task automatic settle_bus();
		finish_command();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all eight timing registers; only called with the block at rest.
	task automatic program_timing(input cfg_regs_t vals);
		settle_bus();
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_wr_en   = 1'b1;
			cfg_index   = REG_IDX_W'(i);
			cfg_wr_data = vals[i];
			timing_reg[i] = vals[i];
		end
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Ticks while idle change nothing, whatever their payload.
	task automatic test_idle_ticks();
		send_item(MODE_TICK, 8'h00, 1'b0);
		send_item(MODE_TICK, 8'hFF, 1'b1);
		send_item(MODE_TICK, 8'h5A, 1'b1);
	endtask

	// One command of each kind with the power-on timing values.
	task automatic test_default_timing();
		send_item(MODE_RESET, 8'h00, 1'b1);
		finish_command();
		send_item(MODE_WRITE, 8'hA5, 1'b0);
		finish_command();
		send_item(MODE_READ, 8'hFF, 1'b0);
		finish_command();
	endtask

	// Commands offered while busy are dropped without counting a tick, and a
	// command right after the finishing tick is taken at once.
	task automatic test_busy_rejects();
		cfg_regs_t vals;
		for (int i = 0; i < NUM_REGS; i++)
			vals[i] = CFG_W'(2);
		program_timing(vals);
		send_item(MODE_RESET, 8'h00, 1'b0);
		send_item(MODE_WRITE, 8'hFF, 1'b1);
		send_item(MODE_READ, 8'h00, 1'b0);
		send_item(MODE_RESET, 8'h81, 1'b1);
		finish_command();
		send_item(MODE_WRITE, 8'h3C, 1'b0);
		send_tick();
		send_item(MODE_READ, 8'hC3, 1'b1);
		finish_command();
		send_item(MODE_READ, 8'h00, 1'b1);
		send_item(MODE_WRITE, 8'h7E, 1'b0);
		finish_command();
	endtask

	// Zero registers behave as a single tick. One write sends only zero bits
	// and one only one bits, so all four write times are used.
	task automatic test_timing_extremes();
		cfg_regs_t vals;
		vals = '0;
		program_timing(vals);
		send_item(MODE_RESET, 8'h00, 1'b0);
		finish_command();
		send_item(MODE_WRITE, 8'h00, 1'b0);
		finish_command();
		send_item(MODE_WRITE, 8'hFF, 1'b1);
		finish_command();
		send_item(MODE_READ, 8'h00, 1'b0);
		finish_command();
	endtask

	// Mostly complete commands with random bytes and levels, and a little
	// noise: ticks while idle and commands thrown in while busy. Timing values
	// are kept short so many commands fit; now and then one runs longer.
	// Only items that the block acts on count toward the goal.
	task automatic test_random_traffic(input int unsigned item_goal,
			input int unsigned tx_pct, input int unsigned rx_pct);
		cfg_regs_t   vals;
		int unsigned counted;
		for (int i = 0; i < NUM_REGS; i++)
			vals[i] = ($urandom_range(5) == 0) ? CFG_W'($urandom_range(40))
				: CFG_W'($urandom_range(4));
		program_timing(vals);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		counted = 0;
		while (counted < item_goal) begin
			if (seq_phase == PH_IDLE) begin
				if ($urandom_range(9) == 0) begin
					send_tick();
				end else begin
					send_item(mode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
					counted++;
				end
			end else if ($urandom_range(19) == 0) begin
				send_item(mode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
			end else begin
				send_tick();
				counted++;
			end
		end
		finish_command();
	endtask

	// The receiver stops taking status for a long stretch while the sender
	// keeps offering items back to back, so the output register fills and
	// the block must hold off its input until the receiver comes back.
	task automatic test_output_stall();
		int unsigned saved_tx;
		saved_tx    = tx_idle_pct;
		tx_idle_pct = 0;
		rx_hold_cycles = HOLD_OFF_CYCLES;
		send_item(MODE_WRITE, 8'($urandom), 1'($urandom));
		repeat (60) send_tick();
		finish_command();
		send_item(MODE_READ, 8'h00, 1'($urandom));
		finish_command();
		tx_idle_pct = saved_tx;
	endtask

	// ------------------------------------------------------------------------
	// Receiver: ready changes on the falling edge. A pending hold-off keeps it
	// low for the requested number of cycles; otherwise it stalls at random.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			res_ch.ready = 1'b0;
		end else begin
			res_ch.ready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] %s", $time, msg);
	endtask

	// Every status transfer is matched against the oldest predicted status.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_status.drive_low = res_ch.drive_low;
			seen_status.busy_res  = res_ch.busy_res;
			seen_status.done_res  = res_ch.done_res;
			seen_status.read_data = res_ch.read_data;
			seen_status.rejected  = res_ch.rejected;
			if (status_q.size() == 0) begin
				log_fault({"status with no item pending: ", status_str(seen_status)});
			end else begin
				due_status = status_q.pop_front();
				if (seen_status.drive_low !== due_status.drive_low
						|| seen_status.busy_res !== due_status.busy_res
						|| seen_status.done_res !== due_status.done_res
						|| seen_status.read_data !== due_status.read_data
						|| seen_status.rejected !== due_status.rejected)
					log_fault({"status mismatch, expected ", status_str(due_status),
						", got ", status_str(seen_status)});
			end
		end
	end

	// Watchdog: a long run of cycles with no transfer at all means a hang.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		// Every input known from time zero, reset held low before the tests start.
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = '0;
		cfg_wr_data       = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.mode       = MODE_TICK;
		cmd_ch.write_data = '0;
		cmd_ch.line_level = 1'b0;
		res_ch.ready      = 1'b0;
		fault_count       = 0;
		quiet_cycles      = 0;
		rx_hold_cycles    = 0;
		tx_idle_pct       = 36;
		rx_idle_pct       = 58;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the sender idling less than the receiver.
		test_idle_ticks();
		test_default_timing();
		test_busy_rejects();
		test_timing_extremes();

		// Random part under the three idling profiles, with the long receiver
		// hold-off in the middle.
		test_random_traffic(100, 36, 58);
		test_random_traffic(100, 58, 36);
		test_output_stall();
		test_random_traffic(100, 0, 0);

		settle_bus();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && status_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/owl_pkg.sv
rtl/owl_cmd_if.sv
rtl/owl_res_if.sv
rtl/owl_cfg_regs.sv
rtl/owl_seq.sv
rtl/one_wire_bus_master_core.sv
dv/tb_top.sv
